// ===== rtl/core/vbn_pkg.sv =====
// Shared types and constants for the vertex bounding-box normalizer.
// Holds the beat payload structs, mode codes and the divider request/response.
// No dependencies.
package vbn_pkg;

    localparam int unsigned COORD_W = 32;
    localparam int unsigned MODE_W  = 2;

    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ACCUM = 2'd1;
    localparam logic [MODE_W-1:0] MODE_NORM  = 2'd2;

    // Divider geometry: dividend is 2*|num|*3*2^28 + D, divisor is 2*D.
    localparam int unsigned DVD_W     = 66;
    localparam int unsigned DVS_W     = 34;
    localparam int unsigned QUOT_W    = 33;
    localparam int unsigned DIV_CNT_W = $clog2(QUOT_W + 1);

    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
    } t_vbn_in;

    typedef struct packed {
        logic signed [COORD_W-1:0] norm_x;
        logic signed [COORD_W-1:0] norm_y;
        logic signed [COORD_W-1:0] norm_z;
        logic                      degenerate;
    } t_vbn_out;

    typedef struct packed {
        logic             go;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic              ovf;
        logic [QUOT_W-1:0] quot;
    } t_div_rsp;

endpackage

// ===== rtl/core/vbn_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Flags overflow when the quotient does not fit in QUOT_W bits.
// Depends on vbn_pkg.
module vbn_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  vbn_pkg::t_div_req i_req,
    output vbn_pkg::t_div_rsp o_rsp
);
    import vbn_pkg::*;

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0]     r_rem;
    logic [QUOT_W-1:0]    r_low;
    logic [QUOT_W-1:0]    r_quot;
    logic [DVS_W-1:0]     r_div;
    logic                 r_ovf;

    logic [QUOT_W-1:0] dvd_high;
    logic              pre_ovf;
    logic [DVS_W-1:0]  trial;
    logic              fits;

    assign dvd_high = i_req.dividend[DVD_W-1:QUOT_W];
    // If the upper part already reaches the divisor, the quotient needs more bits.
    assign pre_ovf  = ({1'b0, dvd_high} >= i_req.divisor);
    assign trial    = {r_rem[DVS_W-2:0], r_low[QUOT_W-1]};
    assign fits     = (trial >= r_div);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.go && !r_busy) begin
            r_busy <= 1'b1;
            r_div  <= i_req.divisor;
            r_ovf  <= pre_ovf;
            r_rem  <= pre_ovf ? '0 : {1'b0, dvd_high};
            r_low  <= i_req.dividend[QUOT_W-1:0];
            r_quot <= '0;
            r_cnt  <= pre_ovf ? '0 : DIV_CNT_W'(QUOT_W);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_rem  <= fits ? (trial - r_div) : trial;
                r_quot <= {r_quot[QUOT_W-2:0], fits};
                r_low  <= {r_low[QUOT_W-2:0], 1'b0};
                r_cnt  <= r_cnt - 1'b1;
            end
        end
    end

    assign o_rsp.done = r_busy && (r_cnt == '0);
    assign o_rsp.ovf  = r_ovf;
    assign o_rsp.quot = r_quot;

    // The remainder stays below the divisor between steps.
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !r_ovf) |-> (r_rem < r_div))
        else $error("divider remainder not below divisor");

    a_done_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.done |=> !r_busy)
        else $error("divider done held past one cycle");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt <= DIV_CNT_W'(QUOT_W)))
        else $error("divider step count out of range");

endmodule

// ===== rtl/core/vertex_bbox_normalizer.sv =====
// Vertex bounding-box normalizer: a beat with mode clear resets the box, mode
// accumulate widens it, both with no result beat. A normalize beat gives one
// result: (v - centre) * 1.5 / largest extent in signed Q2.30, rounded to
// nearest with ties away from zero and saturated, or zeros with degenerate set
// when the box is empty or a single point. After it is accepted, a normalize
// beat keeps the input stalled while it finds the largest extent, checks it,
// then per axis forms the offset and the divider request and waits on the
// shared one-bit-per-cycle divider (which stops early when the quotient cannot
// fit and saturates), which the three axes use in turn, and at last loads the
// output register. An empty or single-point box skips the divider and goes
// straight to the output load. The input also stalls while a finished result
// waits for an earlier one still held in the output register; a held result
// does not by itself block clear or accumulate beats.
module vertex_bbox_normalizer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  vbn_pkg::t_vbn_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output vbn_pkg::t_vbn_out o_out_data
);
    import vbn_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXT,
        S_CHK,
        S_NUM,
        S_MUL,
        S_DIV,
        S_OUT
    } t_state;

    t_state r_state;

    logic signed [COORD_W-1:0] r_lo  [0:2];
    logic signed [COORD_W-1:0] r_hi  [0:2];
    logic signed [COORD_W-1:0] r_v   [0:2];
    logic signed [COORD_W-1:0] r_res [0:2];
    logic                      r_box_valid;
    logic                      r_degen;
    logic [1:0]                r_axis;
    logic [COORD_W-1:0]        r_dmax;
    logic signed [34:0]        r_num;
    logic                      r_neg;
    t_div_req                  r_req;
    logic                      r_out_valid;
    t_vbn_out                  r_out;

    t_div_rsp div_rsp;

    logic                      accept;
    logic signed [COORD_W:0]   ext_diff;
    logic [COORD_W-1:0]        ext_cur;
    logic signed [34:0]        num_cur;
    logic [34:0]               mag;
    logic [36:0]               mag3;
    logic [COORD_W-1:0]        sat_val;
    logic signed [COORD_W-1:0] in_v [0:2];

    vbn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .o_rsp   (div_rsp)
    );

    assign in_v[0] = i_in_data.coord_x;
    assign in_v[1] = i_in_data.coord_y;
    assign in_v[2] = i_in_data.coord_z;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;

    assign ext_diff = {r_hi[r_axis][COORD_W-1], r_hi[r_axis]}
                    - {r_lo[r_axis][COORD_W-1], r_lo[r_axis]};
    assign ext_cur  = ext_diff[COORD_W] ? '0 : ext_diff[COORD_W-1:0];

    // Twice the offset from the box centre, exact.
    assign num_cur = {{2{r_v[r_axis][COORD_W-1]}}, r_v[r_axis], 1'b0}
                   - {{3{r_lo[r_axis][COORD_W-1]}}, r_lo[r_axis]}
                   - {{3{r_hi[r_axis][COORD_W-1]}}, r_hi[r_axis]};

    assign mag  = r_num[34] ? 35'(-r_num) : 35'(r_num);
    assign mag3 = {2'b00, mag} + {1'b0, mag, 1'b0};

    always_comb begin
        if (r_neg) begin
            if (div_rsp.ovf || (div_rsp.quot > 33'h0_8000_0000)) begin
                sat_val = COORD_MIN;
            end else begin
                sat_val = 32'(-div_rsp.quot);
            end
        end else begin
            if (div_rsp.ovf || div_rsp.quot[32] || div_rsp.quot[31]) begin
                sat_val = COORD_MAX;
            end else begin
                sat_val = div_rsp.quot[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_box_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_req.go    <= 1'b0;
            r_axis      <= '0;
            for (int i = 0; i < 3; i++) begin
                r_lo[i] <= COORD_MAX;
                r_hi[i] <= COORD_MIN;
            end
        end else begin
            // In the output state the result load below decides the valid flag.
            if (r_out_valid && !i_out_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (i_in_data.mode)
                            MODE_CLEAR: begin
                                r_box_valid <= 1'b0;
                                for (int i = 0; i < 3; i++) begin
                                    r_lo[i] <= COORD_MAX;
                                    r_hi[i] <= COORD_MIN;
                                end
                            end
                            MODE_ACCUM: begin
                                r_box_valid <= 1'b1;
                                for (int i = 0; i < 3; i++) begin
                                    if (in_v[i] < r_lo[i]) begin
                                        r_lo[i] <= in_v[i];
                                    end
                                    if (in_v[i] > r_hi[i]) begin
                                        r_hi[i] <= in_v[i];
                                    end
                                end
                            end
                            MODE_NORM: begin
                                for (int i = 0; i < 3; i++) begin
                                    r_v[i] <= in_v[i];
                                end
                                r_axis  <= '0;
                                r_dmax  <= '0;
                                r_state <= S_EXT;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_EXT: begin
                    if (ext_cur > r_dmax) begin
                        r_dmax <= ext_cur;
                    end
                    if (r_axis == 2'd2) begin
                        r_axis  <= '0;
                        r_state <= S_CHK;
                    end else begin
                        r_axis <= r_axis + 1'b1;
                    end
                end
                S_CHK: begin
                    if (!r_box_valid || (r_dmax == '0)) begin
                        r_degen <= 1'b1;
                        for (int i = 0; i < 3; i++) begin
                            r_res[i] <= '0;
                        end
                        r_state <= S_OUT;
                    end else begin
                        r_degen <= 1'b0;
                        r_state <= S_NUM;
                    end
                end
                S_NUM: begin
                    r_num   <= num_cur;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_neg          <= r_num[34];
                    r_req.go       <= 1'b1;
                    r_req.dividend <= {mag3, 29'd0} + {34'd0, r_dmax};
                    r_req.divisor  <= {1'b0, r_dmax, 1'b0};
                    r_state        <= S_DIV;
                end
                S_DIV: begin
                    r_req.go <= 1'b0;
                    if (div_rsp.done) begin
                        r_res[r_axis] <= sat_val;
                        if (r_axis == 2'd2) begin
                            r_state <= S_OUT;
                        end else begin
                            r_axis  <= r_axis + 1'b1;
                            r_state <= S_NUM;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid      <= 1'b1;
                        r_out.norm_x     <= r_res[0];
                        r_out.norm_y     <= r_res[1];
                        r_out.norm_z     <= r_res[2];
                        r_out.degenerate <= r_degen;
                        r_state          <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A populated box never has a low bound above its high bound.
    a_box_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_box_valid |-> ((r_lo[0] <= r_hi[0]) && (r_lo[1] <= r_hi[1])
                         && (r_lo[2] <= r_hi[2])))
        else $error("bounding box low above high");

    a_norm_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_in_data.mode == MODE_NORM)) |=> o_in_stall)
        else $error("normalize beat did not start the sequencer");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.degenerate) |->
            ((r_out.norm_x == '0) && (r_out.norm_y == '0) && (r_out.norm_z == '0)))
        else $error("degenerate result with nonzero coordinates");

    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_OUT))
        else $error("result beat raised outside the output state");

endmodule
